// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ase assertion failed");

// Invariant checked at every rising clock edge outside reset.
`define ASE_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ase assertion failed");

`endif

// ===== rtl/ase_pkg.sv =====
package ase_pkg;

  localparam int unsigned TableAddrBitsDef = 10;
  localparam int unsigned DataW   = 32;
  localparam int unsigned EvW     = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned XW      = 42;   // exp argument, Q.32
  localparam int unsigned TW      = 22;   // clamped |z|, Q6.16
  localparam int unsigned DenW    = 34;   // probability divider divisor width

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_PEAK  = 3'd0,
    REG_TARGET_WIDTH = 3'd1,
    REG_QUERY_PEAK   = 3'd2,
    REG_QUERY_WIDTH  = 3'd3,
    REG_EFF_COUNT    = 3'd4
  } cfg_reg_e;

  localparam logic [DataW-1:0] TargetPeakRst  = 32'd0;
  localparam logic [DataW-1:0] TargetWidthRst = 32'd65536;
  localparam logic [DataW-1:0] QueryPeakRst   = 32'd0;
  localparam logic [DataW-1:0] QueryWidthRst  = 32'd65536;
  localparam logic [DataW-1:0] EffCountRst    = 32'd256;

  localparam logic [TW-1:0] ZLimit = 22'h20_0000;        // 32.0 in Q6.16
  localparam logic [XW-1:0] XLimit = 42'h020_0000_0000;  // 32.0 in Q.32

  localparam logic [30:0] Log2eQ30   = 31'd1549082005;
  localparam logic [30:0] SlopeQ30   = 31'd1947552233;
  localparam logic [27:0] AsPQ30     = 28'd248723596;
  localparam logic [28:0] InvSqrt2Pi = 29'd428361012;

  localparam logic signed [35:0] B1Q30 = 36'sd342933307;
  localparam logic signed [35:0] B2Q30 = -36'sd382857446;
  localparam logic signed [35:0] B3Q30 = 36'sd1912847370;
  localparam logic signed [35:0] B4Q30 = -36'sd1955558716;
  localparam logic signed [35:0] B5Q30 = 36'sd1428371292;

  // Stage counts of the datapath.
  localparam int unsigned ZDivSteps  = 22;
  localparam int unsigned PDivSteps  = 32;
  localparam int unsigned ExpLat     = 5;
  localparam int unsigned HornerLat  = 5;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned SideLat    =
    2 + ZDivSteps + 2 + ExpLat + 1 + PDivSteps + HornerLat + 2;
  localparam int unsigned Latency    = 1 + SideLat + 2 + 2 * SqrtSteps + 1;

endpackage

// ===== rtl/ase_div.sv =====
module ase_div import ase_pkg::*; #(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 22,
  parameter int unsigned GW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [GW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [GW-1:0] tag_o
);

  // Restoring division, one quotient bit per stage. num_i < den_i * 2^QW.
  localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_q   [QW];
  logic [RW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [GW-1:0] tag_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int unsigned K = QW - 1 - g;
    logic          in_v;
    logic [RW-1:0] in_rem;
    logic [DW-1:0] in_den;
    logic [QW-1:0] in_quo;
    logic [GW-1:0] in_tag;
    logic [RW-1:0] dsh;
    logic          ge;

    if (g == 0) begin : g_first
      assign in_v   = valid_i;
      assign in_rem = RW'(num_i);
      assign in_den = den_i;
      assign in_quo = '0;
      assign in_tag = tag_i;
    end else begin : g_next
      assign in_v   = v_q[g-1];
      assign in_rem = rem_q[g-1];
      assign in_den = den_q[g-1];
      assign in_quo = quo_q[g-1];
      assign in_tag = tag_q[g-1];
    end

    assign dsh = RW'(in_den) << K;
    assign ge  = in_rem >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= ge ? in_rem - dsh : in_rem;
      den_q[g] <= in_den;
      quo_q[g] <= in_quo | (QW'(ge) << K);
      tag_q[g] <= in_tag;
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ===== rtl/ase_sqrt.sv =====
module ase_sqrt import ase_pkg::*; #(
  parameter int unsigned RW = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [RW-1:0]   rad_i,
  output logic            valid_o,
  output logic [RW/2-1:0] root_o
);

  // Digit-by-digit floor square root, one result bit per stage.
  localparam int unsigned HW  = RW / 2;
  localparam int unsigned RMW = HW + 2;

  logic          v_q    [HW];
  logic [RW-1:0] n_q    [HW];
  logic [RMW-1:0] rem_q [HW];
  logic [HW-1:0] root_q [HW];

  for (genvar g = 0; g < HW; g++) begin : g_stage
    logic           in_v;
    logic [RW-1:0]  in_n;
    logic [RMW-1:0] in_rem;
    logic [HW-1:0]  in_root;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    if (g == 0) begin : g_first
      assign in_v    = valid_i;
      assign in_n    = rad_i;
      assign in_rem  = '0;
      assign in_root = '0;
    end else begin : g_next
      assign in_v    = v_q[g-1];
      assign in_n    = n_q[g-1];
      assign in_rem  = rem_q[g-1];
      assign in_root = root_q[g-1];
    end

    assign rem_sh = {in_rem[RMW-3:0], in_n[RW-1:RW-2]};
    assign trial  = {in_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[g]    <= in_n << 2;
      rem_q[g]  <= ge ? rem_sh - trial : rem_sh;
      root_q[g] <= {in_root[HW-2:0], ge};
    end
  end

  assign valid_o = v_q[HW-1];
  assign root_o  = root_q[HW-1];

endmodule

// ===== rtl/ase_exp.sv =====
module ase_exp import ase_pkg::*; #(
  parameter int unsigned TableAddrBits = TableAddrBitsDef,
  parameter int unsigned GW = 35
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [GW-1:0] tag_i,
  output logic          valid_o,
  output logic [32:0]   y_o,
  output logic [GW-1:0] tag_o
);

  // exp(-x): x*log2(e) = k + f, 2^-f from table with linear interpolation.
  localparam int unsigned N  = 1 << TableAddrBits;
  localparam int unsigned Sh = 32 - TableAddrBits;
  localparam int unsigned AW = TableAddrBits + 1;

  typedef logic [32:0] rom_t [N+1];

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if ((64'(c) * 64'(c)) <= v) begin
        r = c;
      end
    end
    return r;
  endfunction

  function automatic rom_t gen_rom();
    rom_t        tbl;
    logic [31:0] root;
    logic [65:0] prod;
    root = 32'h8000_0000;
    for (int i = 0; i < TableAddrBits; i++) begin
      root = isqrt64({root, 32'd0});
    end
    tbl[0] = 33'h1_0000_0000;
    for (int i = 1; i <= N; i++) begin
      prod   = 66'(tbl[i-1]) * 66'(root) + 66'h8000_0000;
      tbl[i] = prod[64:32];
    end
    return tbl;
  endfunction

  localparam rom_t PowRom = gen_rom();

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic z1_q, z2_q, z3_q, z4_q;
  logic [GW-1:0] t1_q, t2_q, t3_q, t4_q, t5_q;
  logic [4:0]    hi1_q, k2_q, k3_q, k4_q;
  logic [62:0]   plo1_q;
  logic [31:0]   f2_q;
  logic [32:0]   a3_q, b3_q, a4_q, y5_q;
  logic [Sh-1:0] rest3_q;
  logic [32+Sh:0] d4_q;

  logic [38:0]    yv;
  logic [AW-1:0]  idx;
  logic [32:0]    dd;
  logic [32:0]    vv;

  assign yv  = ((39'(hi1_q) * 39'(Log2eQ30)) << 2) + 39'(plo1_q >> 30);
  assign idx = {1'b0, f2_q[31:Sh]};
  assign dd  = a3_q - b3_q;
  assign vv  = a4_q - 33'(d4_q >> Sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    z1_q   <= x_i >= XLimit;
    hi1_q  <= x_i[36:32];
    plo1_q <= 63'(x_i[31:0]) * 63'(Log2eQ30);
    t1_q   <= tag_i;

    z2_q   <= z1_q | (yv[38:37] != 2'd0);
    k2_q   <= yv[36:32];
    f2_q   <= yv[31:0];
    t2_q   <= t1_q;

    a3_q    <= PowRom[idx];
    b3_q    <= PowRom[idx + AW'(1)];
    rest3_q <= f2_q[Sh-1:0];
    k3_q    <= k2_q;
    z3_q    <= z2_q;
    t3_q    <= t2_q;

    d4_q <= (a3_q > b3_q) ? (33 + Sh)'(dd) * (33 + Sh)'(rest3_q) : '0;
    a4_q <= a3_q;
    k4_q <= k3_q;
    z4_q <= z3_q;
    t4_q <= t3_q;

    y5_q <= z4_q ? 33'd0 : (vv >> k4_q);
    t5_q <= t4_q;
  end

  assign valid_o = v5_q;
  assign y_o     = y5_q;
  assign tag_o   = t5_q;

endmodule

// ===== rtl/ase_side.sv =====
module ase_side import ase_pkg::*; #(
  parameter int unsigned TableAddrBits = TableAddrBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DataW-1:0] score_i,
  input  logic [DataW-1:0] peak_i,
  input  logic [DataW-1:0] width_i,
  input  logic [DataW-1:0] eff_i,
  output logic             valid_o,
  output logic [EvW-1:0]   ev_o
);

  localparam logic signed [35:0] HornerC [HornerLat] = '{B4Q30, B3Q30, B2Q30, B1Q30, 36'sd0};

  // |score - peak|
  logic        v1_q, neg1_q;
  logic [32:0] mag1_q;
  logic [32:0] diff;
  assign diff = {score_i[31], score_i} - {peak_i[31], peak_i};

  // scaled numerator and clamp detect
  logic        v2_q, neg2_q, over2_q;
  logic [48:0] num2_q;

  // z division
  logic          zd_v;
  logic [21:0]   zd_q;
  logic [1:0]    zd_tag;

  logic          v3_q, neg3_q;
  logic [TW-1:0] t3_q;

  logic            v4_q, neg4_q;
  logic [XW-1:0]   x4_q;
  logic [DenW-1:0] den4_q;
  logic [49:0]     dprod;
  logic [43:0]     sq;
  logic [52:0]     lprod;

  logic                ex_v;
  logic [32:0]         ex_y;
  logic [DenW:0]       ex_tag;

  logic            v5_q, neg5_q;
  logic [31:0]     phi5_q;
  logic [64:0]     num5_q;
  logic [DenW-1:0] den5_q;
  logic [61:0]     phip;

  logic        pd_v;
  logic [31:0] pd_q;
  logic [32:0] pd_tag;

  logic                v6_q;
  logic [32:0]         p6_q;
  logic                v7_q;
  logic [EvW-1:0]      ev7_q;

  // Horner stage registers
  logic                hv_q   [HornerLat];
  logic signed [35:0]  acc_q  [HornerLat];
  logic [31:0]         hs_q   [HornerLat];
  logic                hn_q   [HornerLat];
  logic [31:0]         hphi_q [HornerLat];

  assign dprod = 50'(AsPQ30) * 50'(t3_q);
  assign sq    = 44'(t3_q) * 44'(t3_q);
  assign lprod = 53'(t3_q) * 53'(SlopeQ30);
  assign phip  = 62'(ex_y) * 62'(InvSqrt2Pi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= zd_v;
      v4_q <= v3_q;
      v5_q <= ex_v;
      v6_q <= hv_q[HornerLat-1];
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q <= diff[32];
    mag1_q <= diff[32] ? 33'd0 - diff : diff;

    num2_q  <= {mag1_q, 16'd0};
    over2_q <= {5'd0, mag1_q, 16'd0} >= {width_i, 22'd0};
    neg2_q  <= neg1_q;

    t3_q   <= (zd_tag[1] || (zd_q > ZLimit)) ? ZLimit : zd_q;
    neg3_q <= zd_tag[0];

    den4_q <= DenW'(dprod >> 16) + DenW'(34'h4000_0000);
    x4_q   <= neg3_q ? sq[42:1] : XW'(lprod[52:14]);
    neg4_q <= neg3_q;

    // normal side: s = 2^60 / denom; logistic side: u * 2^32 / (2^32 + u)
    neg5_q <= ex_tag[DenW];
    phi5_q <= phip[61:30];
    num5_q <= ex_tag[DenW] ? (65'd1 << 60) : {ex_y[31:0], 32'd0} | (65'(ex_y[32]) << 64);
    den5_q <= ex_tag[DenW] ? ex_tag[DenW-1:0] : DenW'(ex_y) + DenW'(34'h1_0000_0000);
  end

  ase_div #(.NW(49), .DW(32), .QW(ZDivSteps), .GW(2)) u_zdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (num2_q),
    .den_i   (width_i),
    .tag_i   ({over2_q, neg2_q}),
    .valid_o (zd_v),
    .quo_o   (zd_q),
    .tag_o   (zd_tag)
  );

  ase_exp #(.TableAddrBits(TableAddrBits), .GW(DenW + 1)) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .x_i     (x4_q),
    .tag_i   ({neg4_q, den4_q}),
    .valid_o (ex_v),
    .y_o     (ex_y),
    .tag_o   (ex_tag)
  );

  ase_div #(.NW(65), .DW(DenW), .QW(PDivSteps), .GW(33)) u_pdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (num5_q),
    .den_i   (den5_q),
    .tag_i   ({neg5_q, phi5_q}),
    .valid_o (pd_v),
    .quo_o   (pd_q),
    .tag_o   (pd_tag)
  );

  // Tail polynomial, one Horner step per stage, truncating toward zero.
  for (genvar h = 0; h < HornerLat; h++) begin : g_horner
    logic               in_v;
    logic signed [35:0] in_acc;
    logic [31:0]        in_s;
    logic               in_n;
    logic [31:0]        in_phi;
    logic signed [68:0] prod;
    logic signed [68:0] adj;

    if (h == 0) begin : g_first
      assign in_v   = pd_v;
      assign in_acc = B5Q30;
      assign in_s   = pd_q;
      assign in_n   = pd_tag[32];
      assign in_phi = pd_tag[31:0];
    end else begin : g_next
      assign in_v   = hv_q[h-1];
      assign in_acc = acc_q[h-1];
      assign in_s   = hs_q[h-1];
      assign in_n   = hn_q[h-1];
      assign in_phi = hphi_q[h-1];
    end

    assign prod = in_acc * $signed({1'b0, in_s});
    assign adj  = prod + (prod[68] ? 69'sd1073741823 : 69'sd0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[h] <= 1'b0;
      end else begin
        hv_q[h] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[h]  <= $signed(adj[65:30]) + HornerC[h];
      hs_q[h]   <= in_s;
      hn_q[h]   <= in_n;
      hphi_q[h] <= in_phi;
    end
  end

  // p-value, then scale by the effective count
  logic [34:0] poly;
  logic [66:0] qp;
  logic [32:0] qc;
  logic [64:0] evp;

  assign poly = (acc_q[HornerLat-1] > 36'sd0) ? acc_q[HornerLat-1][34:0] : 35'd0;
  assign qp   = 67'(poly) * 67'(hphi_q[HornerLat-1]);
  assign qc   = (qp[66:30] > 37'h1_0000_0000) ? 33'h1_0000_0000 : qp[62:30];
  assign evp  = 65'(eff_i) * 65'(p6_q);

  always_ff @(posedge clk_i) begin
    p6_q  <= hn_q[HornerLat-1] ? 33'h1_0000_0000 - qc : {1'b0, hs_q[HornerLat-1]};
    ev7_q <= {7'd0, evp[64:8]};
  end

  assign valid_o = v7_q;
  assign ev_o    = ev7_q;

endmodule

// ===== rtl/alignment_score_evalue.sv =====
// Alignment score to e-value. Each score (signed Q16.16) is placed against the
// target and query score distributions; a side with positive width gives
// effective_count times its tail probability (normal tail below the peak,
// logistic at or above it). Two usable sides combine as the geometric mean,
// one passes through, none gives evalue 0 with no_estimate set. The block
// takes one score per clock and marks each result with valid_o for one
// cycle. busy_o stays low: nothing can hold the pipeline, and the receiver
// must take every result. The depth comes from the bit-per-stage z and
// probability dividers (22 and 32 stages) and the two-bits-per-stage
// 128-bit square root (64 stages). Configuration writes are taken every
// cycle (cfg_ready_o high); write them only while no item is in flight.
// Writes to unused indexes are dropped.
module alignment_score_evalue import ase_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = TableAddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item in
  input  logic               start_i,
  output logic               busy_o,
  input  logic [DataW-1:0]   score_i,
  // result out
  output logic               valid_o,
  output logic [EvW-1:0]     evalue_o,
  output logic [1:0]         sides_used_o,
  output logic               no_estimate_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  logic [DataW-1:0] tpeak_q, twidth_q, qpeak_q, qwidth_q, eff_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpeak_q  <= TargetPeakRst;
      twidth_q <= TargetWidthRst;
      qpeak_q  <= QueryPeakRst;
      qwidth_q <= QueryWidthRst;
      eff_q    <= EffCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TARGET_PEAK:  tpeak_q  <= cfg_data_i;
        REG_TARGET_WIDTH: twidth_q <= cfg_data_i;
        REG_QUERY_PEAK:   qpeak_q  <= cfg_data_i;
        REG_QUERY_WIDTH:  qwidth_q <= cfg_data_i;
        REG_EFF_COUNT:    eff_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Side usable when its width is strictly positive.
  logic use_t, use_q;
  assign use_t = !twidth_q[DataW-1] && (twidth_q != '0);
  assign use_q = !qwidth_q[DataW-1] && (qwidth_q != '0);

  // input register
  logic             in_v_q;
  logic [DataW-1:0] score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_i;
  end

  logic           t_v, q_v;
  logic [EvW-1:0] et, eq;

  ase_side #(.TableAddrBits(TABLE_ADDR_BITS)) u_tgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .score_i (score_q),
    .peak_i  (tpeak_q),
    .width_i (twidth_q),
    .eff_i   (eff_q),
    .valid_o (t_v),
    .ev_o    (et)
  );

  ase_side #(.TableAddrBits(TABLE_ADDR_BITS)) u_qry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .score_i (score_q),
    .peak_i  (qpeak_q),
    .width_i (qwidth_q),
    .eff_i   (eff_q),
    .valid_o (q_v),
    .ev_o    (eq)
  );

  // Geometric mean. A lone side is squared and rooted, which is exact.
  logic [EvW-1:0] mul_a, mul_b;
  assign mul_a = use_t ? et : eq;
  assign mul_b = use_q ? eq : et;

  logic        pp_v_q;
  logic [63:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic        sum_v_q;
  logic [127:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      pp_v_q  <= t_v && q_v;
      sum_v_q <= pp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp00_q <= 64'(mul_a[31:0])  * 64'(mul_b[31:0]);
    pp01_q <= 64'(mul_a[31:0])  * 64'(mul_b[63:32]);
    pp10_q <= 64'(mul_a[63:32]) * 64'(mul_b[31:0]);
    pp11_q <= 64'(mul_a[63:32]) * 64'(mul_b[63:32]);
    sum_q  <= 128'(pp00_q) + (128'(pp01_q) << 32) + (128'(pp10_q) << 32)
            + (128'(pp11_q) << 64);
  end

  logic           sq_v;
  logic [EvW-1:0] sq_root;

  ase_sqrt #(.RW(2 * EvW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_v_q),
    .rad_i   (sum_q),
    .valid_o (sq_v),
    .root_o  (sq_root)
  );

  // output register
  logic           out_v_q;
  logic [EvW-1:0] ev_q;
  logic [1:0]     sides_q;
  logic           none_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q    <= (use_t || use_q) ? sq_root : '0;
    sides_q <= {use_q, use_t};
    none_q  <= !(use_t || use_q);
  end

  assign valid_o       = out_v_q;
  assign evalue_o      = ev_q;
  assign sides_used_o  = sides_q;
  assign no_estimate_o = none_q;

endmodule

// ===== rtl/ase_checker.sv =====
`include "assert_macros.svh"

module ase_checker import ase_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [DataW-1:0]   score_i,
  input logic               valid_o,
  input logic [EvW-1:0]     evalue_o,
  input logic [1:0]         sides_used_o,
  input logic               no_estimate_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [DataW-1:0]   cfg_data_i
);

  // every result follows an accepted item by the fixed pipeline depth
  `ASE_ASSERT_IMP(a_latency, valid_o, $past(start_i && !busy_o, Latency))
  // the flag and the side code agree
  `ASE_ASSERT_IMP(a_flag, valid_o, no_estimate_o == (sides_used_o == 2'd0))
  `ASE_ASSERT_IMP(a_zero, valid_o && no_estimate_o, evalue_o == '0)
  // effective_count * p >> 8 never exceeds 2^56
  `ASE_ASSERT_ALW(a_bound, !valid_o || (evalue_o[63:57] == 7'd0))

endmodule

bind alignment_score_evalue ase_checker u_ase_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ase_pkg::*;

  localparam int unsigned TabBits = TableAddrBitsDef;
  localparam int unsigned TabN    = 1 << TabBits;
  localparam int unsigned RunLimit = 400000;
  localparam logic [63:0] OneQ32  = 64'h1_0000_0000;
  localparam logic [63:0] Low32   = 64'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ENT_ITEM,
    ENT_CFG,
    ENT_SYNC  // hold until the pipeline is empty and settled
  } ent_kind_e;

  typedef struct {
    ent_kind_e       kind;
    logic [2:0]      idx;
    logic [31:0]     data;
    int unsigned     gap;
  } stim_t;

  typedef struct {
    logic [63:0] evalue;
    logic [1:0]  sides;
    logic        none;
  } evalue_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [DataW-1:0]  score_i = '0;
  logic              valid_o;
  logic [EvW-1:0]    evalue_o;
  logic [1:0]        sides_used_o;
  logic              no_estimate_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0]  cfg_data_i = '0;

  alignment_score_evalue dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .score_i,
    .valid_o, .evalue_o, .sides_used_o, .no_estimate_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Predictor: own copy of the registers and the 2^(-i/N) power ROM.
  // ---------------------------------------------------------------------
  logic [31:0] m_tpeak  = TargetPeakRst;
  logic [31:0] m_twidth = TargetWidthRst;
  logic [31:0] m_qpeak  = QueryPeakRst;
  logic [31:0] m_qwidth = QueryWidthRst;
  logic [31:0] m_eff    = EffCountRst;
  logic [63:0] pow_rom [0:TabN];

  stim_t   stim_q[$];
  evalue_t pending_evalues[$];
  int      n_errors = 0;

  // floor of the exact square root of a 128-bit value
  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  initial begin
    logic [63:0] root;
    root = 64'h8000_0000;
    for (int i = 0; i < TabBits; i++) root = isqrt128({64'd0, root} << 32);
    pow_rom[0] = OneQ32;
    for (int i = 1; i <= TabN; i++) pow_rom[i] = (pow_rom[i-1] * root + 64'h8000_0000) >> 32;
  end

  // exp(-x), x in Q.32, result Q0.32
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
    logic [63:0] y, k, f, idx, rest, a, b, v;
    int unsigned sh;
    sh = 32 - TabBits;
    if (x >= {22'd0, XLimit}) return 64'd0;
    y = (x >> 32) * 64'(Log2eQ30) * 64'd4 + (((x & Low32) * 64'(Log2eQ30)) >> 30);
    k = y >> 32;
    if (k >= 64'd32) return 64'd0;
    f = y & Low32;
    idx = f >> sh;
    rest = f & ((64'd1 << sh) - 64'd1);
    a = pow_rom[idx];
    b = pow_rom[idx + 1];
    v = (a > b) ? a - (((a - b) * rest) >> sh) : a;
    return v >> k;
  endfunction

  // upper normal tail, t in Q16.16, result Q0.32 (polynomial approximation)
  function automatic logic [63:0] normal_tail_q32(input logic [63:0] t);
    logic [63:0] denom, poly, phi, q;
    logic signed [63:0] s, acc;
    denom = (64'd1 << 30) + ((64'(AsPQ30) * t) >> 16);
    s = $signed((64'd1 << 60) / denom);
    acc = 64'(B5Q30);
    acc = acc * s / 64'sd1073741824 + 64'(B4Q30);
    acc = acc * s / 64'sd1073741824 + 64'(B3Q30);
    acc = acc * s / 64'sd1073741824 + 64'(B2Q30);
    acc = acc * s / 64'sd1073741824 + 64'(B1Q30);
    acc = acc * s / 64'sd1073741824;
    poly = (acc > 0) ? acc : 64'd0;
    phi = (exp_neg_q32((t * t) >> 1) * 64'(InvSqrt2Pi)) >> 30;
    q = (poly * phi) >> 30;
    return (q > OneQ32) ? OneQ32 : q;
  endfunction

  function automatic logic [63:0] logistic_q32(input logic [63:0] t);
    logic [63:0] u;
    u = exp_neg_q32((t * 64'(SlopeQ30)) >> 14);
    if (u >= OneQ32) return 64'h8000_0000;
    return (u << 32) / (OneQ32 + u);
  endfunction

  function automatic logic [63:0] side_evalue(input logic [31:0] sc, input logic [31:0] pk,
                                              input logic [31:0] wd);
    logic signed [63:0] diff;
    logic [63:0] mag, t, p;
    diff = 64'($signed(sc)) - 64'($signed(pk));
    mag = (diff < 0) ? -diff : diff;
    t = (mag << 16) / {32'd0, wd};
    if (t > 64'(ZLimit)) t = 64'(ZLimit);
    p = (diff < 0) ? OneQ32 - normal_tail_q32(t) : logistic_q32(t);
    return ({32'd0, m_eff} * p) >> 8;
  endfunction

  function automatic evalue_t evalue_of(input logic [31:0] sc);
    evalue_t r;
    logic use_t, use_q;
    logic [63:0] et, eq;
    use_t = $signed(m_twidth) > 0;
    use_q = $signed(m_qwidth) > 0;
    et = use_t ? side_evalue(sc, m_tpeak, m_twidth) : 64'd0;
    eq = use_q ? side_evalue(sc, m_qpeak, m_qwidth) : 64'd0;
    if (use_t && use_q) r.evalue = isqrt128({64'd0, et} * {64'd0, eq});
    else if (use_t) r.evalue = et;
    else r.evalue = eq;
    r.sides = {use_q, use_t};
    r.none = !(use_t || use_q);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: works off stim_q; items wait out their own gap afterward.
  // ---------------------------------------------------------------------
  int unsigned gap_left = 0;
  int unsigned settle = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic  n_start, n_cfg;
    stim_t ent;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      score_i <= '0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
      gap_left = 0;
      settle = 0;
    end else begin
      n_start = start_i;
      n_cfg = cfg_valid_i;
      // a presented item or write stays until it is taken
      if (!((start_i && busy_o) || (cfg_valid_i && !cfg_ready_o))) begin
        n_start = 1'b0;
        n_cfg = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          ent = stim_q[0];
          case (ent.kind)
            ENT_SYNC: begin
              if (pending_evalues.size() == 0) begin
                if (settle >= Latency + 4) begin
                  void'(stim_q.pop_front());
                  settle = 0;
                end else begin
                  settle++;
                end
              end else begin
                settle = 0;
              end
            end
            ENT_ITEM: begin
              n_start = 1'b1;
              score_i <= ent.data;
              gap_left = ent.gap;
              void'(stim_q.pop_front());
            end
            default: begin
              n_cfg = 1'b1;
              cfg_index_i <= ent.idx;
              cfg_data_i <= ent.data;
              void'(stim_q.pop_front());
            end
          endcase
        end
      end
      start_i <= n_start;
      cfg_valid_i <= n_cfg;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: register writes, accepted scores, results.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    evalue_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (pending_evalues.size() == 0) begin
          $display("%0t: result with nothing expected: ev %h sides %0d none %0b",
                   $time, evalue_o, sides_used_o, no_estimate_o);
          n_errors++;
        end else begin
          want = pending_evalues.pop_front();
          if (evalue_o !== want.evalue) begin
            $display("%0t: evalue exp %h got %h", $time, want.evalue, evalue_o);
            n_errors++;
          end
          if (sides_used_o !== want.sides) begin
            $display("%0t: sides_used exp %0d got %0d", $time, want.sides, sides_used_o);
            n_errors++;
          end
          if (no_estimate_o !== want.none) begin
            $display("%0t: no_estimate exp %0b got %0b", $time, want.none, no_estimate_o);
            n_errors++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TARGET_PEAK:  m_tpeak  <= cfg_data_i;
          REG_TARGET_WIDTH: m_twidth <= cfg_data_i;
          REG_QUERY_PEAK:   m_qpeak  <= cfg_data_i;
          REG_QUERY_WIDTH:  m_qwidth <= cfg_data_i;
          REG_EFF_COUNT:    m_eff    <= cfg_data_i;
          default: ;  // unused index, dropped
        endcase
      end
      if (start_i && !busy_o) pending_evalues = {pending_evalues, evalue_of(score_i)};
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  bit calm = 1'b0;  // phase without idle gaps

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic enqueue_stim(input stim_t ent);
    stim_q = {stim_q, ent};
  endtask

  task automatic add_score(input logic [31:0] sc);
    enqueue_stim('{ENT_ITEM, 3'd0, sc, pick_gap()});
  endtask

  task automatic add_write(input logic [2:0] idx, input logic [31:0] d);
    enqueue_stim('{ENT_CFG, idx, d, 0});
  endtask

  task automatic add_sync();
    enqueue_stim('{ENT_SYNC, 3'd0, 32'd0, 0});
  endtask

  function automatic logic [31:0] pick_width();
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return 32'h8000_0000 | $urandom();
      2: return 32'd1;
      3: return 32'h7FFF_FFFF;
      4: return $urandom();
      default: return $urandom_range(32'h0000_1000, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_peak();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_eff();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd256;
      default: return $urandom();
    endcase
  endfunction

  // score near the given peak, within ten widths, or within 2^26 for odd widths
  function automatic logic [31:0] near_peak(input logic [31:0] pk, input logic [31:0] wd);
    longint span, off;
    span = ($signed(wd) > 0 && wd < 32'h0100_0000) ? longint'(wd) * 10 : 64'd1 << 26;
    off = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1) - span;
    return 32'(longint'($signed(pk)) + off);
  endfunction

  initial begin
    logic [31:0] tp, tw, qp, qw;
    // directed: reset settings, field extremes, near the peak
    add_score(32'd0);
    add_score(32'h7FFF_FFFF);
    add_score(32'h8000_0000);
    add_score(32'd1);
    add_score(32'hFFFF_FFFF);
    add_score(32'h0001_0000);
    add_score(32'hFFFF_0000);
    add_score(32'h0020_0000);
    add_score(32'hFFC0_0000);
    add_sync();
    // huge width: score one LSB below the peak truncates z to zero
    add_write(REG_TARGET_PEAK, 32'h7FFF_FFFF);
    add_write(REG_TARGET_WIDTH, 32'h7FFF_FFFF);
    add_write(REG_QUERY_WIDTH, 32'h8000_0000);  // query side off
    add_write(REG_EFF_COUNT, 32'hFFFF_FFFF);
    add_write(3'd5, 32'hFFFF_FFFF);             // unused indexes
    add_write(3'd6, 32'd0);
    add_write(3'd7, 32'h1234_5678);
    add_score(32'h7FFF_FFFE);
    add_score(32'h7FFF_FFFF);
    add_score(32'h8000_0000);
    add_sync();
    // neither side usable
    add_write(REG_TARGET_WIDTH, 32'd0);
    add_write(REG_QUERY_WIDTH, 32'hFFFF_FFFF);
    add_score(32'h0000_1234);
    add_score(32'h8000_0000);
    add_sync();
    // query side only, smallest width, zero count
    add_write(REG_QUERY_WIDTH, 32'd1);
    add_write(REG_QUERY_PEAK, 32'h8000_0000);
    add_write(REG_EFF_COUNT, 32'd0);
    add_score(32'h8000_0001);
    add_score(32'h7FFF_FFFF);
    add_sync();
    add_write(REG_EFF_COUNT, 32'd256);

    // random phases, each with fresh settings
    for (int ph = 0; ph < 10; ph++) begin
      add_sync();
      calm = ($urandom_range(0, 3) == 0);
      tp = pick_peak();
      tw = pick_width();
      qp = pick_peak();
      qw = pick_width();
      if (ph < 6 && $signed(tw) <= 0) tw = $urandom_range(32'h0000_8000, 32'h0004_0000);
      if (ph < 4 && $signed(qw) <= 0) qw = $urandom_range(32'h0000_8000, 32'h0004_0000);
      add_write(REG_TARGET_PEAK, tp);
      add_write(REG_TARGET_WIDTH, tw);
      add_write(REG_QUERY_PEAK, qp);
      add_write(REG_QUERY_WIDTH, qw);
      add_write(REG_EFF_COUNT, pick_eff());
      for (int i = 0; i < 150; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: add_score($urandom());
          3, 4, 5: add_score(near_peak(tp, tw));
          default: add_score(near_peak(qp, qw));
        endcase
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: everything sent, every result back, then let the pipe settle
    @(posedge clk_i);
    #1;
    while (stim_q.size() != 0 || pending_evalues.size() != 0 || start_i) begin
      @(posedge clk_i);
      #1;
    end
    repeat (Latency + 10) @(posedge clk_i);
    #1;
    if (n_errors == 0 && pending_evalues.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("%0t: run limit hit, %0d results outstanding", $time, pending_evalues.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ase_pkg.sv
rtl/ase_div.sv
rtl/ase_sqrt.sv
rtl/ase_exp.sv
rtl/ase_side.sv
rtl/alignment_score_evalue.sv
rtl/ase_checker.sv
test/testbench.sv
